[rtl/asc_pkg.sv]
// Shared constants for the box/sphere contact pipeline.
// No dependencies.
package asc_pkg;

  localparam int unsigned CoordWidthDef = 24;

endpackage

[rtl/asc_if.sv]
// Valid/ready channel interfaces for the box/sphere contact pipeline.
// Depends on asc_pkg for the default coordinate width.
interface asc_in_if #(
  parameter int unsigned CW = asc_pkg::CoordWidthDef
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] box_center_x;
  logic signed [CW-1:0] box_center_y;
  logic signed [CW-1:0] box_center_z;
  logic        [CW-2:0] box_half_x;
  logic        [CW-2:0] box_half_y;
  logic        [CW-2:0] box_half_z;
  logic signed [CW-1:0] sphere_center_x;
  logic signed [CW-1:0] sphere_center_y;
  logic signed [CW-1:0] sphere_center_z;
  logic        [CW-2:0] sphere_radius;

  modport source (
    output valid, box_center_x, box_center_y, box_center_z,
    output box_half_x, box_half_y, box_half_z,
    output sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, box_center_x, box_center_y, box_center_z,
    input  box_half_x, box_half_y, box_half_z,
    input  sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    output ready
  );
endinterface

interface asc_out_if #(
  parameter int unsigned CW = asc_pkg::CoordWidthDef
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] push_x;
  logic signed [CW-1:0] push_y;
  logic signed [CW-1:0] push_z;

  modport source (output valid, hit, push_x, push_y, push_z, input ready);
  modport sink (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

[rtl/asc_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on asc_pkg for the default width.
module asc_isqrt #(
  parameter int unsigned RW = asc_pkg::CoordWidthDef
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);
  import asc_pkg::*;

  localparam int unsigned NW = 2 * RW;
  localparam int unsigned MW = RW + 2;

  logic [MW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [NW-1:0] n_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [MW-1:0] rem_p, cand, trial;
    logic [RW-1:0] root_p;
    logic [NW-1:0] n_p;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign n_p    = n_q[k-1];
    end

    always_comb begin
      cand  = {rem_p[MW-3:0], n_p[NW-1:NW-2]};
      trial = {root_p, 2'b01};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cand >= trial) begin
          rem_q[k]  <= cand - trial;
          root_q[k] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cand;
          root_q[k] <= {root_p[RW-2:0], 1'b0};
        end
        n_q[k] <= {n_p[NW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

[rtl/asc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit W-1 bits. Depends on asc_pkg for the default width.
module asc_div #(
  parameter int unsigned W = asc_pkg::CoordWidthDef
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] num_i,
  input  logic [W:0]     den_i,
  output logic [W-2:0]   quo_o
);
  import asc_pkg::*;

  localparam int unsigned H  = W - 1;
  localparam int unsigned DW = W + 1;

  logic [DW-1:0] rem_q [H];
  logic [DW-1:0] den_q [H];
  logic [H-1:0]  lo_q  [H];
  logic [H-1:0]  q_q   [H];

  for (genvar k = 0; k < H; k++) begin : g_stg
    logic [DW-1:0] rem_p, den_p;
    logic [H-1:0]  lo_p, q_p;
    logic [DW:0]   cand;

    if (k == 0) begin : g_first
      assign rem_p = num_i[2*W-1:H];
      assign den_p = den_i;
      assign lo_p  = num_i[H-1:0];
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign lo_p  = lo_q[k-1];
      assign q_p   = q_q[k-1];
    end

    assign cand = {rem_p, lo_p[H-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cand >= {1'b0, den_p}) begin
          rem_q[k] <= DW'(cand - {1'b0, den_p});
          q_q[k]   <= {q_p[H-2:0], 1'b1};
        end else begin
          rem_q[k] <= cand[DW-1:0];
          q_q[k]   <= {q_p[H-2:0], 1'b0};
        end
        den_q[k] <= den_p;
        lo_q[k]  <= {lo_p[H-2:0], 1'b0};
      end
    end
  end

  assign quo_o = q_q[H-1];

endmodule

[rtl/aabb_sphere_collision_mtv.sv]
// Box/sphere contact test with minimum translation vector, fully pipelined.
// The pipeline has 2*COORD_WIDTH+7 register stages, most of them in the
// bit-per-stage square root and divider.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry output buffer absorbs a stall.
// Reset clears all valid bits and the delayed side and tail records; data registers are not reset.
// Depends on asc_pkg, asc_if, asc_isqrt, asc_div.
module aabb_sphere_collision_mtv #(
  parameter int unsigned COORD_WIDTH = asc_pkg::CoordWidthDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  asc_in_if.sink   in_i,
  asc_out_if.source out_o
);
  import asc_pkg::*;

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned H = W - 1;

  typedef struct packed {
    logic                v;
    logic                hit;
    logic                nz;
    logic [2:0]          pos;
    logic [2:0][H-1:0]   a;
    logic [H-1:0]        r;
  } side_t;

  typedef struct packed {
    logic       v;
    logic       ok;
    logic       hit;
    logic [2:0] pos;
  } tail_t;

  typedef struct packed {
    logic              hit;
    logic [2:0][W-1:0] push;
  } res_t;

  logic en;

  // stage 1: box bounds
  logic signed [W-1:0] bc [3];
  logic        [H-1:0] bh [3];
  logic signed [W-1:0] sc [3];
  logic                s1_v_q;
  logic signed [W:0]   s1_lo_q [3];
  logic signed [W:0]   s1_hi_q [3];
  logic signed [W-1:0] s1_sc_q [3];
  logic        [H-1:0] s1_r_q;

  assign bc[0] = in_i.box_center_x;
  assign bc[1] = in_i.box_center_y;
  assign bc[2] = in_i.box_center_z;
  assign bh[0] = in_i.box_half_x;
  assign bh[1] = in_i.box_half_y;
  assign bh[2] = in_i.box_half_z;
  assign sc[0] = in_i.sphere_center_x;
  assign sc[1] = in_i.sphere_center_y;
  assign sc[2] = in_i.sphere_center_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_lo_q[i] <= $signed({bc[i][W-1], bc[i]}) - $signed({2'b00, bh[i]});
        s1_hi_q[i] <= $signed({bc[i][W-1], bc[i]}) + $signed({2'b00, bh[i]});
        s1_sc_q[i] <= sc[i];
      end
      s1_r_q <= in_i.sphere_radius;
    end
  end

  // stage 2: clamp and offset magnitude
  logic signed [W:0]   sce [3];
  logic signed [W:0]   cl  [3];
  logic signed [W+1:0] dd  [3];
  logic                s2_v_q;
  logic        [W:0]   s2_a_q [3];
  logic        [2:0]   s2_pos_q;
  logic        [H-1:0] s2_r_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sce[i] = $signed({s1_sc_q[i][W-1], s1_sc_q[i]});
      if (sce[i] < s1_lo_q[i]) begin
        cl[i] = s1_lo_q[i];
      end else if (sce[i] > s1_hi_q[i]) begin
        cl[i] = s1_hi_q[i];
      end else begin
        cl[i] = sce[i];
      end
      dd[i] = $signed({cl[i][W], cl[i]}) - $signed({sce[i][W], sce[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_a_q[i]   <= dd[i][W+1] ? (W+1)'(-dd[i]) : dd[i][W:0];
        s2_pos_q[i] <= sce[i] < s1_lo_q[i];
      end
      s2_r_q <= s1_r_q;
    end
  end

  // stage 3: squares
  logic                s3_v_q;
  logic                s3_far_q;
  logic [2*H-1:0]      s3_sq_q [3];
  logic [2*H-1:0]      s3_rr_q;
  logic [2:0][H-1:0]   s3_a_q;
  logic [2:0]          s3_pos_q;
  logic [H-1:0]        s3_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_far_q <= (s2_a_q[0] > {2'b00, s2_r_q}) || (s2_a_q[1] > {2'b00, s2_r_q})
               || (s2_a_q[2] > {2'b00, s2_r_q});
      for (int i = 0; i < 3; i++) begin
        s3_sq_q[i] <= s2_a_q[i][H-1:0] * s2_a_q[i][H-1:0];
        s3_a_q[i]  <= s2_a_q[i][H-1:0];
      end
      s3_rr_q  <= s2_r_q * s2_r_q;
      s3_pos_q <= s2_pos_q;
      s3_r_q   <= s2_r_q;
    end
  end

  // stage 4: sum of squares and hit test
  logic [2*W-1:0] dsq;
  side_t          s4_q;
  logic [2*W-1:0] s4_dsq_q;

  assign dsq = (2*W)'(s3_sq_q[0]) + (2*W)'(s3_sq_q[1]) + (2*W)'(s3_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (en) begin
      s4_q.v   <= s3_v_q;
      s4_q.hit <= !s3_far_q && (dsq <= (2*W)'(s3_rr_q));
      s4_q.nz  <= dsq != '0;
      s4_q.pos <= s3_pos_q;
      s4_q.a   <= s3_a_q;
      s4_q.r   <= s3_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_dsq_q <= dsq;
    end
  end

  // square root, side data delayed alongside
  logic [W-1:0] root;
  side_t        sd_q [W];

  asc_isqrt #(.RW(W)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s4_dsq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < W; k++) sd_q[k] <= '0;
    end else if (en) begin
      sd_q[0] <= s4_q;
      for (int k = 1; k < W; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // penetration depth
  side_t        p1_q;
  logic [W-1:0] p1_dist_q;
  logic [H-1:0] p1_pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else if (en) begin
      p1_q <= sd_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_dist_q <= root;
      p1_pen_q  <= ({1'b0, sd_q[W-1].r} >= root) ? H'(sd_q[W-1].r - root[H-1:0]) : '0;
    end
  end

  // dividend and divisor
  tail_t          p2_q;
  logic [2*W-1:0] p2_n_q [3];
  logic [W:0]     p2_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_q <= '0;
    end else if (en) begin
      p2_q.v   <= p1_q.v;
      p2_q.ok  <= p1_q.hit && p1_q.nz;
      p2_q.hit <= p1_q.hit;
      p2_q.pos <= p1_q.pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_n_q[i] <= (2*W)'({(2*H)'(p1_q.a[i]) * (2*H)'(p1_pen_q), 1'b0})
                   + (2*W)'(p1_dist_q);
      end
      p2_d_q <= {p1_dist_q, 1'b0};
    end
  end

  // dividers, one per axis
  logic [H-1:0] quo [3];
  tail_t        td_q [H];

  for (genvar i = 0; i < 3; i++) begin : g_div
    asc_div #(.W(W)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (p2_n_q[i]),
      .den_i (p2_d_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < H; k++) td_q[k] <= '0;
    end else if (en) begin
      td_q[0] <= p2_q;
      for (int k = 1; k < H; k++) td_q[k] <= td_q[k-1];
    end
  end

  // sign and zero masking
  logic         f_v_q;
  res_t         f_q;
  res_t         f_d;

  always_comb begin
    f_d.hit = td_q[H-1].hit;
    for (int i = 0; i < 3; i++) begin
      if (!td_q[H-1].ok) begin
        f_d.push[i] = '0;
      end else if (td_q[H-1].pos[i]) begin
        f_d.push[i] = W'(-{1'b0, quo[i]});
      end else begin
        f_d.push[i] = {1'b0, quo[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= td_q[H-1].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q <= f_d;
    end
  end

  // output register with skid entry
  logic out_v_q, skid_v_q, take;
  res_t out_q, skid_q;

  assign en   = !skid_v_q;
  assign take = out_o.ready || !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      out_v_q  <= skid_v_q || f_v_q;
      skid_v_q <= 1'b0;
    end else if (f_v_q && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : f_q;
    end else if (f_v_q && en) begin
      skid_q <= f_q;
    end
  end

  assign in_i.ready   = en;
  assign out_o.valid  = out_v_q;
  assign out_o.hit    = out_q.hit;
  assign out_o.push_x = out_q.push[0];
  assign out_o.push_y = out_q.push[1];
  assign out_o.push_z = out_q.push[2];

endmodule
